[src/stisect_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stisect_pkg
// Shared widths, types and register indexes of the segment/triangle unit.
// ----------------------------------------------------------------------------
package stisect_pkg;

    localparam int COORD_WIDTH   = 24;
    localparam int OUT_FRAC_BITS = 24;
    localparam int OUT_WIDTH     = 32;
    // quotient magnitude bound is 2^PRE_SHIFT (the 128 limit)
    localparam int PRE_SHIFT     = 7;

    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int COF_W   = PROD_W + 1;
    localparam int SPLIT_W = (COF_W + 1) / 2;
    localparam int LO_W    = SPLIT_W + 1 + DIFF_W;
    localparam int HI_W    = COF_W - SPLIT_W + DIFF_W;
    localparam int VOL_W   = COF_W + DIFF_W + 2;
    localparam int NUM_W   = VOL_W + 2;
    localparam int MAG_W   = NUM_W;
    localparam int DIV_W   = MAG_W + PRE_SHIFT;
    localparam int QUO_W   = PRE_SHIFT + OUT_FRAC_BITS;
    localparam int SQUO_W  = QUO_W + 1;

    localparam int VOL_LAT  = 6;
    localparam int PREP_LAT = 3;
    localparam int PIPE_LAT = VOL_LAT + PREP_LAT + QUO_W;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SEG_START_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEG_START_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEG_START_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEG_END_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEG_END_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SEG_END_Z   = 3'd5;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [OUT_WIDTH-1:0]   out_t;
    typedef logic signed [VOL_W-1:0]       vol_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    // sideband of one division: result sign and safe flag
    typedef struct packed {
        logic neg;
        logic ok;
    } div_side_t;

    typedef struct packed {
        out_t line_param;
        out_t weight_u;
        out_t weight_v;
        out_t weight_w;
        logic status;
        logic inside_res;
    } result_t;

endpackage

[src/segment_triangle_intersect_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_triangle_intersect_unit
// Crossing of a configured segment with a stream of triangles: plane
// parameter t and barycentric weights in Q8.24, with degenerate status.
// ----------------------------------------------------------------------------
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  input   | in_valid/in_ready, vert_{a,b,c}_xyz  | in
//  output  | out_valid/out_ready, line_param,     | out
//          | weight_u/v/w, status, inside_res     |
//  config  | cfg_wr_en, cfg_idx, cfg_wdata        | in
//
//  One word enters per cycle while in_ready is high; the path to the
//  output register is 6 volume stages, 3 prep stages and 31 divider stages.
//  The divider pipeline, one quotient bit per stage, sets the depth.
//  Reset clears valid bits, output/skid flags and config registers.
//  All stages advance together while the skid slot is empty; a stalled
//  output fills the skid, then in_ready drops until it drains.
// ----------------------------------------------------------------------------
module segment_triangle_intersect_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [stisect_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  stisect_pkg::coord_t               cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  stisect_pkg::coord_t               vert_a_x,
    input  stisect_pkg::coord_t               vert_a_y,
    input  stisect_pkg::coord_t               vert_a_z,
    input  stisect_pkg::coord_t               vert_b_x,
    input  stisect_pkg::coord_t               vert_b_y,
    input  stisect_pkg::coord_t               vert_b_z,
    input  stisect_pkg::coord_t               vert_c_x,
    input  stisect_pkg::coord_t               vert_c_y,
    input  stisect_pkg::coord_t               vert_c_z,
    output logic                              out_valid,
    input  logic                              out_ready,
    output stisect_pkg::out_t                 line_param,
    output stisect_pkg::out_t                 weight_u,
    output stisect_pkg::out_t                 weight_v,
    output stisect_pkg::out_t                 weight_w,
    output logic                              status,
    output logic                              inside_res
);
    import stisect_pkg::*;

    // ---------------- configuration ----------------
    point_t s0_reg, s1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_reg <= '0;
            s1_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx)
                REG_SEG_START_X: s0_reg.x <= cfg_wdata;
                REG_SEG_START_Y: s0_reg.y <= cfg_wdata;
                REG_SEG_START_Z: s0_reg.z <= cfg_wdata;
                REG_SEG_END_X:   s1_reg.x <= cfg_wdata;
                REG_SEG_END_Y:   s1_reg.y <= cfg_wdata;
                REG_SEG_END_Z:   s1_reg.z <= cfg_wdata;
                default: ;  // unknown index: ignored
            endcase
        end
    end

    // ---------------- global advance ----------------
    logic en;
    logic skid_valid_reg;
    logic valid_reg [PIPE_LAT];

    assign en       = !skid_valid_reg;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_LAT; i++)
                valid_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < PIPE_LAT; i++)
                valid_reg[i] <= valid_reg[i-1];
        end
    end

    // ---------------- five volumes ----------------
    point_t va, vb, vc;
    vol_t   vol_top, vol_bot, vol_sd0, vol_sd1, vol_sd2;

    assign va = '{x: vert_a_x, y: vert_a_y, z: vert_a_z};
    assign vb = '{x: vert_b_x, y: vert_b_y, z: vert_b_z};
    assign vc = '{x: vert_c_x, y: vert_c_y, z: vert_c_z};

    stisect_vol u_vol_top (.clk(clk), .en(en), .p(va), .q(vb), .r(vc),
                           .s(s0_reg), .vol(vol_top));
    stisect_vol u_vol_bot (.clk(clk), .en(en), .p(va), .q(vb), .r(vc),
                           .s(s1_reg), .vol(vol_bot));
    stisect_vol u_vol_sd2 (.clk(clk), .en(en), .p(va), .q(vb), .r(s0_reg),
                           .s(s1_reg), .vol(vol_sd2));
    stisect_vol u_vol_sd0 (.clk(clk), .en(en), .p(vb), .q(vc), .r(s0_reg),
                           .s(s1_reg), .vol(vol_sd0));
    stisect_vol u_vol_sd1 (.clk(clk), .en(en), .p(vc), .q(va), .r(s0_reg),
                           .s(s1_reg), .vol(vol_sd1));

    // ---------------- divider prep ----------------
    // slot 0: t = top/(top-bot); slots 1..3: u,v,w = side/total
    logic signed [NUM_W-1:0] num_reg [4];
    logic signed [NUM_W-1:0] den_t_reg, tot_reg;
    logic [MAG_W-1:0]        mnum_reg [4];
    logic [MAG_W-1:0]        mden_reg [4];
    logic                    neg_reg [4];
    logic                    nz_reg [4];
    logic [DIV_W-1:0]        rem0_reg [4];
    logic [DIV_W-1:0]        dvs0_reg [4];
    div_side_t               side0_reg [4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg[0] <= NUM_W'(vol_top);
            num_reg[1] <= NUM_W'(vol_sd0);
            num_reg[2] <= NUM_W'(vol_sd1);
            num_reg[3] <= NUM_W'(vol_sd2);
            den_t_reg  <= NUM_W'(vol_top) - NUM_W'(vol_bot);
            tot_reg    <= NUM_W'(vol_sd0) + NUM_W'(vol_sd1) + NUM_W'(vol_sd2);
            for (int j = 0; j < 4; j++)
            begin
                // magnitudes and result sign
                mnum_reg[j] <= num_reg[j][NUM_W-1] ? MAG_W'(-num_reg[j]) : MAG_W'(num_reg[j]);
                if (j == 0)
                begin
                    mden_reg[j] <= den_t_reg[NUM_W-1] ? MAG_W'(-den_t_reg)
                                                      : MAG_W'(den_t_reg);
                    neg_reg[j]  <= num_reg[j][NUM_W-1] ^ den_t_reg[NUM_W-1];
                    nz_reg[j]   <= (den_t_reg != '0);
                end
                else
                begin
                    mden_reg[j] <= tot_reg[NUM_W-1] ? MAG_W'(-tot_reg) : MAG_W'(tot_reg);
                    neg_reg[j]  <= num_reg[j][NUM_W-1] ^ tot_reg[NUM_W-1];
                    nz_reg[j]   <= (tot_reg != '0);
                end
                // safe when |num| < 128*|den|; divisor pre-scaled by 128
                rem0_reg[j]      <= DIV_W'(mnum_reg[j]);
                dvs0_reg[j]      <= {mden_reg[j], {PRE_SHIFT{1'b0}}};
                side0_reg[j].neg <= neg_reg[j];
                side0_reg[j].ok  <= nz_reg[j] &&
                                    (DIV_W'(mnum_reg[j]) < {mden_reg[j], {PRE_SHIFT{1'b0}}});
            end
        end
    end

    // ---------------- four dividers ----------------
    logic [QUO_W-1:0]         quo [4];
    div_side_t                side [4];
    logic signed [SQUO_W-1:0] qs [4];

    genvar j;
    for (j = 0; j < 4; j++)
    begin : g_div
        stisect_div u_div (
            .clk     (clk),
            .en      (en),
            .rem_in  (rem0_reg[j]),
            .dvs_in  (dvs0_reg[j]),
            .side_in (side0_reg[j]),
            .quo     (quo[j]),
            .side_out(side[j])
        );
        assign qs[j] = side[j].neg ? -$signed({1'b0, quo[j]}) : $signed({1'b0, quo[j]});
    end

    // ---------------- result select ----------------
    result_t res;

    always_comb
    begin
        res        = '0;
        res.status = 1'b1;
        if (side[0].ok)
        begin
            res.line_param = OUT_WIDTH'(qs[0]);
            if (side[1].ok && side[2].ok && side[3].ok)
            begin
                res.weight_u   = OUT_WIDTH'(qs[1]);
                res.weight_v   = OUT_WIDTH'(qs[2]);
                res.weight_w   = OUT_WIDTH'(qs[3]);
                res.status     = 1'b0;
                // sign taken before the wrap to the output width
                res.inside_res = (qs[1] >= 0) && (qs[2] >= 0) && (qs[3] >= 0);
            end
        end
    end

    // ---------------- output register with skid slot ----------------
    logic    out_valid_reg;
    result_t out_reg, skid_reg;
    logic    pipe_out;

    assign pipe_out = valid_reg[PIPE_LAT-1] && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && out_ready)
        begin
            if (skid_valid_reg)
                skid_valid_reg <= 1'b0;
            else
                out_valid_reg <= pipe_out;
        end
        else if (!out_valid_reg)
            out_valid_reg <= pipe_out;
        else if (pipe_out)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_valid_reg && out_ready)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (pipe_out)
                out_reg <= res;
        end
        else if (!out_valid_reg)
        begin
            if (pipe_out)
                out_reg <= res;
        end
        else if (pipe_out)
            skid_reg <= res;
    end

    assign out_valid  = out_valid_reg;
    assign line_param = out_reg.line_param;
    assign weight_u   = out_reg.weight_u;
    assign weight_v   = out_reg.weight_v;
    assign weight_w   = out_reg.weight_w;
    assign status     = out_reg.status;
    assign inside_res = out_reg.inside_res;

endmodule

[src/stisect_vol.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stisect_vol
// Six-stage signed tetrahedron volume, -det[p-s; q-s; r-s], exact.
// ----------------------------------------------------------------------------
module stisect_vol (
    input  logic               clk,
    input  logic               en,
    input  stisect_pkg::point_t p,
    input  stisect_pkg::point_t q,
    input  stisect_pkg::point_t r,
    input  stisect_pkg::point_t s,
    output stisect_pkg::vol_t   vol
);
    import stisect_pkg::*;

    logic signed [DIFF_W-1:0] a1_reg [3];
    logic signed [DIFF_W-1:0] a2_reg [3];
    logic signed [DIFF_W-1:0] a3_reg [3];
    logic signed [DIFF_W-1:0] bx_reg, by_reg, bz_reg;
    logic signed [DIFF_W-1:0] cx_reg, cy_reg, cz_reg;
    logic signed [PROD_W-1:0] bycz_reg, cybz_reg, bxcz_reg, cxbz_reg, bxcy_reg, cxby_reg;
    logic signed [COF_W-1:0]  cof_reg [3];
    logic signed [LO_W-1:0]   lo_reg [3];
    logic signed [HI_W-1:0]   hi_reg [3];
    logic signed [VOL_W-1:0]  term_reg [3];
    logic signed [VOL_W-1:0]  vol_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // edge vectors
            a1_reg[0] <= DIFF_W'(p.x) - DIFF_W'(s.x);
            a1_reg[1] <= DIFF_W'(p.y) - DIFF_W'(s.y);
            a1_reg[2] <= DIFF_W'(p.z) - DIFF_W'(s.z);
            bx_reg    <= DIFF_W'(q.x) - DIFF_W'(s.x);
            by_reg    <= DIFF_W'(q.y) - DIFF_W'(s.y);
            bz_reg    <= DIFF_W'(q.z) - DIFF_W'(s.z);
            cx_reg    <= DIFF_W'(r.x) - DIFF_W'(s.x);
            cy_reg    <= DIFF_W'(r.y) - DIFF_W'(s.y);
            cz_reg    <= DIFF_W'(r.z) - DIFF_W'(s.z);
            // 2x2 minors products
            bycz_reg  <= by_reg * cz_reg;
            cybz_reg  <= cy_reg * bz_reg;
            bxcz_reg  <= bx_reg * cz_reg;
            cxbz_reg  <= cx_reg * bz_reg;
            bxcy_reg  <= bx_reg * cy_reg;
            cxby_reg  <= cx_reg * by_reg;
            cof_reg[0] <= COF_W'(bycz_reg) - COF_W'(cybz_reg);
            cof_reg[1] <= COF_W'(bxcz_reg) - COF_W'(cxbz_reg);
            cof_reg[2] <= COF_W'(bxcy_reg) - COF_W'(cxby_reg);
            for (int k = 0; k < 3; k++)
            begin
                a2_reg[k]   <= a1_reg[k];
                a3_reg[k]   <= a2_reg[k];
                // cofactor split into two partial products
                lo_reg[k]   <= $signed({1'b0, cof_reg[k][SPLIT_W-1:0]}) * a3_reg[k];
                hi_reg[k]   <= $signed(cof_reg[k][COF_W-1:SPLIT_W]) * a3_reg[k];
                term_reg[k] <= (VOL_W'(hi_reg[k]) <<< SPLIT_W) + VOL_W'(lo_reg[k]);
            end
            vol_reg <= term_reg[1] - term_reg[0] - term_reg[2];
        end
    end

    assign vol = vol_reg;

endmodule

[src/stisect_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stisect_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module stisect_div (
    input  logic                          clk,
    input  logic                          en,
    input  logic [stisect_pkg::DIV_W-1:0] rem_in,
    input  logic [stisect_pkg::DIV_W-1:0] dvs_in,
    input  stisect_pkg::div_side_t        side_in,
    output logic [stisect_pkg::QUO_W-1:0] quo,
    output stisect_pkg::div_side_t        side_out
);
    import stisect_pkg::*;

    logic [DIV_W-1:0] rem_reg  [QUO_W];
    logic [DIV_W-1:0] dvs_reg  [QUO_W];
    logic [QUO_W-1:0] quo_reg  [QUO_W];
    div_side_t        side_reg [QUO_W];
    logic [DIV_W-1:0] rem_next [QUO_W];
    logic [QUO_W-1:0] quo_next [QUO_W];

    genvar k;
    for (k = 0; k < QUO_W; k++)
    begin : g_stage
        logic [DIV_W-1:0] rem_src;
        logic [DIV_W-1:0] dvs_src;
        logic [QUO_W-1:0] quo_src;
        logic [DIV_W:0]   shifted;
        logic             ge;

        if (k == 0)
        begin : g_first
            assign rem_src = rem_in;
            assign dvs_src = dvs_in;
            assign quo_src = '0;
        end
        else
        begin : g_next
            assign rem_src = rem_reg[k-1];
            assign dvs_src = dvs_reg[k-1];
            assign quo_src = quo_reg[k-1];
        end

        assign shifted     = {rem_src, 1'b0};
        assign ge          = (shifted >= {1'b0, dvs_src});
        assign rem_next[k] = ge ? DIV_W'(shifted - {1'b0, dvs_src}) : DIV_W'(shifted);
        assign quo_next[k] = {quo_src[QUO_W-2:0], ge};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next[k];
                dvs_reg[k]  <= dvs_src;
                quo_reg[k]  <= quo_next[k];
                side_reg[k] <= (k == 0) ? side_in : side_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    assign quo      = quo_reg[QUO_W-1];
    assign side_out = side_reg[QUO_W-1];

endmodule

[src/stisect_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stisect_chk
// Port-level checks of the segment/triangle unit, bound to the top level.
// ----------------------------------------------------------------------------
module stisect_chk (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input stisect_pkg::out_t line_param,
    input stisect_pkg::out_t weight_u,
    input stisect_pkg::out_t weight_v,
    input stisect_pkg::out_t weight_w,
    input logic              status,
    input logic              inside_res
);
    import stisect_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(line_param) &&
        $stable(weight_u) && $stable(status))
        else $error("stalled output word changed");

    a_fail_outside: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> !inside_res)
        else $error("inside flag set on degenerate word");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> weight_u == '0 && weight_v == '0 && weight_w == '0)
        else $error("weights nonzero on degenerate word");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no output word pending");

    a_ready_back: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> in_ready)
        else $error("input not ready after output drained");

endmodule

bind segment_triangle_intersect_unit stisect_chk u_stisect_chk (.*);

[tb/tb_segment_triangle_intersect_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_triangle_intersect_unit
// Streams triangles against a configured segment and checks the plane
// parameter, barycentric weights, status and inside flag of every word
// against an exact wide-integer prediction kept in the bench.
// ----------------------------------------------------------------------------
module tb_segment_triangle_intersect_unit;

    import stisect_pkg::*;

    // exact signed volume arithmetic, wide enough for any product chain
    typedef logic signed [159:0] wide_t;
    typedef logic        [159:0] uwide_t;

    typedef struct {
        point_t a;
        point_t b;
        point_t c;
    } tri_t;

    localparam int RUN_LIMIT   = 600000;
    localparam int COORD_MAX   = (1 << (COORD_WIDTH - 1)) - 1;
    localparam int COORD_MIN   = -(1 << (COORD_WIDTH - 1));
    localparam int HOLD_CYCLES = 3 * PIPE_LAT + 60;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_idx;
    coord_t               cfg_wdata;
    logic                 in_valid;
    logic                 in_ready;
    coord_t               vert_a_x, vert_a_y, vert_a_z;
    coord_t               vert_b_x, vert_b_y, vert_b_z;
    coord_t               vert_c_x, vert_c_y, vert_c_z;
    logic                 out_valid;
    logic                 out_ready;
    out_t                 line_param, weight_u, weight_v, weight_w;
    logic                 status;
    logic                 inside_res;

    // bench copy of the segment registers
    coord_t  seg_reg [6];
    // predicted crossings, oldest first
    result_t crossing_q [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_on        = 1'b0;
    int err_cnt        = 0;
    int cycle_cnt      = 0;

    segment_triangle_intersect_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_idx    (cfg_idx),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .vert_a_x   (vert_a_x),
        .vert_a_y   (vert_a_y),
        .vert_a_z   (vert_a_z),
        .vert_b_x   (vert_b_x),
        .vert_b_y   (vert_b_y),
        .vert_b_z   (vert_b_z),
        .vert_c_x   (vert_c_x),
        .vert_c_y   (vert_c_y),
        .vert_c_z   (vert_c_z),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .line_param (line_param),
        .weight_u   (weight_u),
        .weight_v   (weight_v),
        .weight_w   (weight_w),
        .status     (status),
        .inside_res (inside_res)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // signed tetrahedron volume -det[p-s; q-s; r-s], exact
    function automatic wide_t tet_volume(point_t p, point_t q, point_t r, point_t s);
        wide_t ax, ay, az, bx, by, bz, cx, cy, cz;
        ax = p.x - s.x; ay = p.y - s.y; az = p.z - s.z;
        bx = q.x - s.x; by = q.y - s.y; bz = q.z - s.z;
        cx = r.x - s.x; cy = r.y - s.y; cz = r.z - s.z;
        return -((ax * (by * cz - cy * bz)) - (ay * (bx * cz - cx * bz))
                 + (az * (bx * cy - cx * by)));
    endfunction

    // fixed-point quotient truncated toward zero; 0 when not safe
    function automatic bit frac_div(input wide_t num, input wide_t den, output longint q);
        uwide_t an, bd, quo;
        q = 0;
        if (den == 0)
            return 1'b0;
        an = (num < 0) ? -num : num;
        bd = (den < 0) ? -den : den;
        if (an >= (bd << PRE_SHIFT))
            return 1'b0;
        quo = (an << OUT_FRAC_BITS) / bd;
        q = longint'(quo[63:0]);
        if ((num < 0) != (den < 0))
            q = -q;
        return 1'b1;
    endfunction

    function automatic result_t predict_crossing(tri_t t);
        point_t  s0, s1;
        wide_t   top, bot, sd0, sd1, sd2, tot;
        longint  qt, qu, qv, qw;
        bit      ok0, ok1, ok2;
        result_t r;
        s0 = '{x: seg_reg[0], y: seg_reg[1], z: seg_reg[2]};
        s1 = '{x: seg_reg[3], y: seg_reg[4], z: seg_reg[5]};
        top = tet_volume(t.a, t.b, t.c, s0);
        bot = tet_volume(t.a, t.b, t.c, s1);
        sd2 = tet_volume(t.a, t.b, s0, s1);
        sd0 = tet_volume(t.b, t.c, s0, s1);
        sd1 = tet_volume(t.c, t.a, s0, s1);
        r = '0;
        r.status = 1'b1;
        if (frac_div(top, top - bot, qt))
        begin
            r.line_param = qt[31:0];
            tot = sd0 + sd1 + sd2;
            ok0 = frac_div(sd0, tot, qu);
            ok1 = frac_div(sd1, tot, qv);
            ok2 = frac_div(sd2, tot, qw);
            if (ok0 && ok1 && ok2)
            begin
                r.weight_u   = qu[31:0];
                r.weight_v   = qv[31:0];
                r.weight_w   = qw[31:0];
                r.status     = 1'b0;
                // sign test on the full quotients, not the wrapped ones
                r.inside_res = (qu >= 0) && (qv >= 0) && (qw >= 0);
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // valid is left high after acceptance; in this task only an idle gap lowers it
    task automatic send_triangle(tri_t t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        vert_a_x <= t.a.x; vert_a_y <= t.a.y; vert_a_z <= t.a.z;
        vert_b_x <= t.b.x; vert_b_y <= t.b.y; vert_b_z <= t.b.z;
        vert_c_x <= t.c.x; vert_c_y <= t.c.y; vert_c_z <= t.c.z;
        do
            @(posedge clk);
        while (!in_ready);
        crossing_q.push_back(predict_crossing(t));
    endtask

    // all words out, then a pipeline's worth of quiet cycles
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (crossing_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 8) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, coord_t data);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        if (idx <= REG_SEG_END_Z)
            seg_reg[idx] = data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_segment(point_t s0, point_t s1);
        write_reg(REG_SEG_START_X, s0.x);
        write_reg(REG_SEG_START_Y, s0.y);
        write_reg(REG_SEG_START_Z, s0.z);
        write_reg(REG_SEG_END_X, s1.x);
        write_reg(REG_SEG_END_Y, s1.y);
        write_reg(REG_SEG_END_Z, s1.z);
    endtask

    function automatic point_t pt(int x, int y, int z);
        point_t p;
        p.x = COORD_WIDTH'(x);
        p.y = COORD_WIDTH'(y);
        p.z = COORD_WIDTH'(z);
        return p;
    endfunction

    function automatic point_t rand_point_full();
        point_t p;
        logic [31:0] r;
        r = $urandom; p.x = r[23:0];
        r = $urandom; p.y = r[23:0];
        r = $urandom; p.z = r[23:0];
        return p;
    endfunction

    // point spread randomly around a center within the given span
    function automatic point_t jitter(point_t ctr, int span);
        point_t p;
        p.x = COORD_WIDTH'(int'(ctr.x) + $signed($urandom_range(2 * span)) - span);
        p.y = COORD_WIDTH'(int'(ctr.y) + $signed($urandom_range(2 * span)) - span);
        p.z = COORD_WIDTH'(int'(ctr.z) + $signed($urandom_range(2 * span)) - span);
        return p;
    endfunction

    // triangle around a point on (or just past) the segment line
    function automatic tri_t crossing_triangle();
        tri_t   t;
        point_t ctr;
        int     k, span;
        k    = int'($urandom_range(24)) - 4;
        span = 1 << $urandom_range(18, 3);
        ctr.x = COORD_WIDTH'(int'(seg_reg[0])
                             + (int'(seg_reg[3]) - int'(seg_reg[0])) * k / 16);
        ctr.y = COORD_WIDTH'(int'(seg_reg[1])
                             + (int'(seg_reg[4]) - int'(seg_reg[1])) * k / 16);
        ctr.z = COORD_WIDTH'(int'(seg_reg[2])
                             + (int'(seg_reg[5]) - int'(seg_reg[2])) * k / 16);
        t.a = jitter(ctr, span);
        t.b = jitter(ctr, span);
        t.c = jitter(ctr, span);
        return t;
    endfunction

    function automatic tri_t noise_triangle();
        tri_t t;
        t.a = rand_point_full();
        t.b = rand_point_full();
        t.c = rand_point_full();
        return t;
    endfunction

    function automatic point_t rand_point_mid();
        return pt($signed($urandom_range(1 << 21)) - (1 << 20),
                  $signed($urandom_range(1 << 21)) - (1 << 20),
                  $signed($urandom_range(1 << 21)) - (1 << 20));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // zero-length segment after reset: every word is degenerate
    task automatic test_reset_segment();
        send_triangle('{a: pt(4096, 0, 0), b: pt(0, 4096, 0), c: pt(0, 0, 4096)});
        send_triangle(noise_triangle());
        wait_drained();
    endtask

    task automatic test_directed();
        tri_t t;
        // vertical segment through the origin, 16384 each way
        load_segment(pt(0, 0, -16384), pt(0, 0, 16384));
        // hit in the middle of a flat triangle
        send_triangle('{a: pt(-8192, -8192, 0), b: pt(8192, -8192, 0), c: pt(0, 8192, 0)});
        // plane crossed, but off to the side: negative weight
        send_triangle('{a: pt(4096, 4096, 0), b: pt(12288, 4096, 0), c: pt(4096, 12288, 0)});
        // plane crossed beyond the segment ends
        send_triangle('{a: pt(-8192, -8192, 40960), b: pt(8192, -8192, 40960),
                        c: pt(0, 8192, 40960)});
        // triangle plane contains the segment direction: t denominator zero
        send_triangle('{a: pt(-4096, 0, 0), b: pt(4096, 0, 0), c: pt(0, 0, 4096)});
        // all vertices equal
        send_triangle('{a: pt(100, 200, 300), b: pt(100, 200, 300), c: pt(100, 200, 300)});
        // collinear vertices
        send_triangle('{a: pt(0, 0, 0), b: pt(4096, 4096, 0), c: pt(8192, 8192, 0)});
        // hit through a vertex and along an edge: zero weights count as inside
        send_triangle('{a: pt(0, 0, 0), b: pt(8192, 0, 0), c: pt(0, 8192, 0)});
        send_triangle('{a: pt(-4096, 0, 0), b: pt(4096, 0, 0), c: pt(0, 8192, 0)});
        // tiny triangle far from the crossing: weights too large
        send_triangle('{a: pt(4096000, 0, 0), b: pt(4096001, 0, 0), c: pt(4096000, 1, 0)});
        // coordinate extremes
        send_triangle('{a: pt(COORD_MIN, COORD_MIN, COORD_MIN),
                        b: pt(COORD_MAX, COORD_MAX, COORD_MAX),
                        c: pt(COORD_MAX, COORD_MIN, 0)});
        send_triangle('{a: pt(COORD_MAX, COORD_MIN, COORD_MIN),
                        b: pt(COORD_MIN, COORD_MAX, COORD_MIN),
                        c: pt(COORD_MIN, COORD_MIN, COORD_MAX)});
        wait_drained();

        // short segment, far plane: t out of range; then a plane crossed mid-segment
        load_segment(pt(0, 0, 0), pt(0, 0, 2));
        send_triangle('{a: pt(-8192, -8192, 4096000), b: pt(8192, -8192, 4096000),
                        c: pt(0, 8192, 4096000)});
        send_triangle('{a: pt(-8192, -8192, 1), b: pt(8192, -8192, 1), c: pt(0, 8192, 1)});
        wait_drained();

        // extreme segments with extreme triangles
        load_segment(pt(COORD_MIN, COORD_MIN, COORD_MIN), pt(COORD_MAX, COORD_MAX, COORD_MAX));
        t = '{a: pt(COORD_MAX, COORD_MIN, 0), b: pt(COORD_MIN, COORD_MAX, 0),
              c: pt(COORD_MIN, COORD_MIN, COORD_MAX)};
        send_triangle(t);
        send_triangle(noise_triangle());
        wait_drained();
        load_segment(pt(COORD_MAX, COORD_MIN, COORD_MAX), pt(COORD_MIN, COORD_MAX, COORD_MIN));
        send_triangle(t);
        send_triangle(noise_triangle());
        wait_drained();
    endtask

    // writes to indexes past the last register must leave the segment alone
    task automatic test_unused_index();
        load_segment(pt(0, 0, -16384), pt(0, 0, 16384));
        write_reg(3'd6, COORD_WIDTH'(COORD_MIN));
        write_reg(3'd7, COORD_WIDTH'(COORD_MAX));
        send_triangle('{a: pt(-8192, -8192, 0), b: pt(8192, -8192, 0), c: pt(0, 8192, 0)});
        wait_drained();
    endtask

    // mostly triangles built around the segment, the rest full-range noise (only noise for an extreme segment)
    task automatic test_traffic(int n, int snd, int rcv, bit extreme_seg);
        point_t s0, s1;
        send_idle_pct  = snd;
        recv_stall_pct = rcv;
        if (extreme_seg)
        begin
            s0 = rand_point_full();
            s1 = rand_point_full();
        end
        else
        begin
            s0 = rand_point_mid();
            s1 = rand_point_mid();
        end
        load_segment(s0, s1);
        for (int i = 0; i < n; i++)
        begin
            if (!extreme_seg && $urandom_range(99) < 80)
                send_triangle(crossing_triangle());
            else
                send_triangle(noise_triangle());
        end
        wait_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // receiver holds off long enough for the pipe and skid to fill
    task automatic test_backpressure();
        load_segment(rand_point_mid(), rand_point_mid());
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // hold-off counted on its own while the sender keeps offering words
        fork
            begin
                hold_on = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_on = 1'b0;
            end
        join_none
        for (int i = 0; i < 70; i++)
            send_triangle(crossing_triangle());
        // sender pause: everything must come out before the next burst
        wait_drained();
        for (int i = 0; i < 20; i++)
            send_triangle(crossing_triangle());
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Output side: per-field compare
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        if (out_valid && out_ready)
        begin
            if (crossing_q.size() == 0)
            begin
                $display("%0t: unexpected word line_param=%h", $time, line_param);
                err_cnt++;
            end
            else
            begin
                want = crossing_q.pop_front();
                if (line_param !== want.line_param)
                begin
                    $display("%0t: line_param exp %h got %h", $time, want.line_param,
                             line_param);
                    err_cnt++;
                end
                if (weight_u !== want.weight_u)
                begin
                    $display("%0t: weight_u exp %h got %h", $time, want.weight_u, weight_u);
                    err_cnt++;
                end
                if (weight_v !== want.weight_v)
                begin
                    $display("%0t: weight_v exp %h got %h", $time, want.weight_v, weight_v);
                    err_cnt++;
                end
                if (weight_w !== want.weight_w)
                begin
                    $display("%0t: weight_w exp %h got %h", $time, want.weight_w, weight_w);
                    err_cnt++;
                end
                if (status !== want.status)
                begin
                    $display("%0t: status exp %b got %b", $time, want.status, status);
                    err_cnt++;
                end
                if (inside_res !== want.inside_res)
                begin
                    $display("%0t: inside_res exp %b got %b", $time, want.inside_res,
                             inside_res);
                    err_cnt++;
                end
            end
        end
    end

    // receiver: random stalls, or held off for a long stretch
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_on)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > RUN_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_idx   = '0;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        {vert_a_x, vert_a_y, vert_a_z} = '0;
        {vert_b_x, vert_b_y, vert_b_z} = '0;
        {vert_c_x, vert_c_y, vert_c_z} = '0;
        foreach (seg_reg[i])
            seg_reg[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_segment();
        test_directed();
        test_unused_index();
        test_traffic(200, 0, 0, 1'b0);
        test_traffic(200, 72, 0, 1'b0);
        test_traffic(200, 0, 72, 1'b0);
        test_traffic(150, 11, 11, 1'b0);
        test_traffic(30, 11, 11, 1'b1);
        test_backpressure();

        wait_drained();
        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
